// ===== rtl/schm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Schrage makespan block.
// Used by schm_ctrl, schm_dp and schrage_makespan; depends on nothing.
package schm_pkg;

  // Request field widths on the stream ports
  localparam int unsigned FIELD_W      = 16;
  localparam int unsigned IN_DATA_W    = 3 * FIELD_W;
  localparam int unsigned MAKESPAN_W   = 24;
  localparam logic [MAKESPAN_W-1:0] MAKESPAN_MAX = '1;

  // Parameter defaults
  localparam int unsigned MAX_TASKS_DEF = 64;
  localparam int unsigned TIME_BITS_DEF = 16;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_COMMIT,
    ST_ACCUM,
    ST_OUT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // store the accepted task
    logic init;        // clear time and makespan, arm task counter
    logic scan_start;  // rewind the scan and clear the running best
    logic scan_run;    // issue store reads
    logic jump;        // move time to the smallest pending release
    logic commit;      // mark the pick and advance time
    logic accum;       // fold completion plus delivery into the makespan
    logic out_load;    // load the result register and clear the task set
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_done;   // every stored task has been evaluated
    logic found;       // a ready task was picked in the last scan
    logic left_zero;   // no unscheduled task remains
    logic out_free;    // result register can take a new result
  } status_t;

endpackage

// ===== rtl/schm_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the Schrage makespan block.
// Depends on schm_pkg for the state enum and the command and status structs.
module schm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  input  logic             s_axis_tlast_i,
  output logic             s_axis_tready_o,
  input  schm_pkg::status_t status_i,
  output schm_pkg::cmd_t   cmd_o
);

  schm_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= schm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      schm_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.load = 1'b1;
          if (s_axis_tlast_i) begin
            state_d = schm_pkg::ST_START;
          end
        end
      end
      schm_pkg::ST_START: begin
        cmd_o.init       = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = schm_pkg::ST_SCAN;
      end
      schm_pkg::ST_SCAN: begin
        if (status_i.scan_done) begin
          if (status_i.found) begin
            state_d = schm_pkg::ST_COMMIT;
          end else begin
            // Nothing ready: jump time and rescan
            cmd_o.jump       = 1'b1;
            cmd_o.scan_start = 1'b1;
          end
        end else begin
          cmd_o.scan_run = 1'b1;
        end
      end
      schm_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = schm_pkg::ST_ACCUM;
      end
      schm_pkg::ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        if (status_i.left_zero) begin
          state_d = schm_pkg::ST_OUT;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = schm_pkg::ST_SCAN;
        end
      end
      schm_pkg::ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = schm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = schm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/schm_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the Schrage makespan block: task stores, scan pipeline,
// time and makespan registers, result register. Depends on schm_pkg.
module schm_dp #(
  parameter int unsigned MAX_TASKS = schm_pkg::MAX_TASKS_DEF,
  parameter int unsigned TIME_BITS = schm_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  schm_pkg::cmd_t                    cmd_i,
  output schm_pkg::status_t                 status_o,
  input  logic [schm_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  logic                              m_axis_tready_i,
  output logic                              m_axis_tvalid_o,
  output logic [schm_pkg::MAKESPAN_W-1:0]   m_axis_tdata_o,
  output logic                              m_axis_tuser_o
);

  localparam int unsigned SW = (TIME_BITS < schm_pkg::FIELD_W) ? TIME_BITS : schm_pkg::FIELD_W;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned TW = SW + $clog2(MAX_TASKS + 2);
  localparam int unsigned XW = (TW > schm_pkg::MAKESPAN_W) ? TW : schm_pkg::MAKESPAN_W;
  localparam int unsigned FW = schm_pkg::FIELD_W;

  // Task stores, written while loading; marks are also set on commit
  logic [SW-1:0] rel_mem  [MAX_TASKS];
  logic [SW-1:0] proc_mem [MAX_TASKS];
  logic [SW-1:0] del_mem  [MAX_TASKS];
  logic          mark_mem [MAX_TASKS];

  logic [CW-1:0] count_q, left_q, scan_idx_q;
  logic          ovf_q;
  logic [TW-1:0] time_q, maxend_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic [SW-1:0] rel_rd_q, proc_rd_q, del_rd_q;
  logic          mark_rd_q;
  logic          best_found_q;
  logic [AW-1:0] best_idx_q;
  logic [SW-1:0] best_rel_q, best_proc_q, best_del_q, min_rel_q;
  logic          out_vld_q, out_drop_q;
  logic [schm_pkg::MAKESPAN_W-1:0] out_span_q;

  logic          store_ok, issue, cand, better, pending;
  logic [TW-1:0] end_sum;
  logic [XW-1:0] maxend_x;

  assign store_ok = (count_q != CW'(MAX_TASKS));
  assign issue    = cmd_i.scan_run && (scan_idx_q != count_q);
  assign pending  = rd_vld_q && !mark_rd_q;
  assign cand     = pending && (TW'(rel_rd_q) <= time_q);
  assign better   = !best_found_q || (del_rd_q > best_del_q) ||
                    ((del_rd_q == best_del_q) && (rel_rd_q < best_rel_q));
  assign end_sum  = time_q + TW'(best_del_q);
  assign maxend_x = XW'(maxend_q);

  // Store writes: task fields on load, scheduled marks on load and commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && store_ok) begin
      rel_mem[count_q[AW-1:0]]  <= s_axis_tdata_i[SW-1:0];
      proc_mem[count_q[AW-1:0]] <= s_axis_tdata_i[FW+SW-1:FW];
      del_mem[count_q[AW-1:0]]  <= s_axis_tdata_i[2*FW+SW-1:2*FW];
    end
    if (cmd_i.commit) begin
      mark_mem[best_idx_q] <= 1'b1;
    end else if (cmd_i.load && store_ok) begin
      mark_mem[count_q[AW-1:0]] <= 1'b0;
    end
  end

  // Registered store reads for the scan
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rel_rd_q  <= rel_mem[scan_idx_q[AW-1:0]];
      proc_rd_q <= proc_mem[scan_idx_q[AW-1:0]];
      del_rd_q  <= del_mem[scan_idx_q[AW-1:0]];
      mark_rd_q <= mark_mem[scan_idx_q[AW-1:0]];
      rd_idx_q  <= scan_idx_q[AW-1:0];
    end
  end

  // Task count and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.out_load) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.load) begin
      if (store_ok) begin
        count_q <= count_q + CW'(1);
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  // Scan address and read-valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
      end else if (issue) begin
        scan_idx_q <= scan_idx_q + CW'(1);
      end
    end
  end

  // Running best ready task and smallest pending release
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_found_q <= 1'b0;
      min_rel_q    <= '1;
    end else if (cmd_i.scan_start) begin
      best_found_q <= 1'b0;
      min_rel_q    <= '1;
    end else begin
      if (pending && (rel_rd_q < min_rel_q)) begin
        min_rel_q <= rel_rd_q;
      end
      if (cand && better) begin
        best_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cand && better) begin
      best_idx_q  <= rd_idx_q;
      best_rel_q  <= rel_rd_q;
      best_proc_q <= proc_rd_q;
      best_del_q  <= del_rd_q;
    end
  end

  // Time, remaining tasks and makespan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q   <= '0;
      maxend_q <= '0;
      left_q   <= '0;
    end else if (cmd_i.init) begin
      time_q   <= '0;
      maxend_q <= '0;
      left_q   <= count_q;
    end else begin
      if (cmd_i.jump) begin
        time_q <= TW'(min_rel_q);
      end else if (cmd_i.commit) begin
        time_q <= time_q + TW'(best_proc_q);
        left_q <= left_q - CW'(1);
      end
      if (cmd_i.accum && (end_sum > maxend_q)) begin
        maxend_q <= end_sum;
      end
    end
  end

  // Result register, saturate the makespan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_drop_q <= ovf_q;
      if (maxend_x > XW'(schm_pkg::MAKESPAN_MAX)) begin
        out_span_q <= schm_pkg::MAKESPAN_MAX;
      end else begin
        out_span_q <= maxend_x[schm_pkg::MAKESPAN_W-1:0];
      end
    end
  end

  assign status_o.scan_done = (scan_idx_q == count_q) && !rd_vld_q;
  assign status_o.found     = best_found_q;
  assign status_o.left_zero = (left_q == '0);
  assign status_o.out_free  = !out_vld_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_span_q;
  assign m_axis_tuser_o  = out_drop_q;

  // Checks
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_run |-> (scan_idx_q <= count_q))
    else $error("scan address passed the task count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_TASKS)) else $error("task count beyond store depth");

  a_commit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> best_found_q) else $error("commit without a ready task");

  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (left_q != '0)) else $error("commit with no task left");

endmodule

// ===== rtl/schrage_makespan.sv =====
`timescale 1ns / 1ps
// Top level of the Schrage makespan block: controller plus datapath.
// Depends on schm_pkg, schm_ctrl and schm_dp.
//
// Usage: tasks arrive on the s_axis channel, one request per cycle while
// the block is loading. Each request carries release, processing and
// delivery time in tdata; tlast marks the final task of a set. Up to
// MAX_TASKS tasks are stored; further tasks are dropped and flagged.
// After the tlast request the block schedules the stored N tasks with the
// non-preemptive Schrage rule and sends one result on m_axis: the makespan
// in tdata (saturated to 24 bits) and the drop flag in tuser.
// Each pick takes one scan over the store through the single registered
// store read port, then a commit and an accumulate step; a scan that
// finds no released task costs one extra scan before the pick. A start
// step precedes the first scan and a result load follows the last pick.
// s_axis_tready stays low during scheduling and while a new result waits
// for the result register to empty; a result held by a stalled receiver
// does not block loading of the next set.
// Reset clears the task count, the flags and the result valid; the stores
// need no clearing pass.
module schrage_makespan #(
  parameter int unsigned MAX_TASKS = schm_pkg::MAX_TASKS_DEF,
  parameter int unsigned TIME_BITS = schm_pkg::TIME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // release_time [15:0], processing_time [31:16], delivery_time [47:32]
  input  logic [schm_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  input  logic                             s_axis_tlast_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // makespan [23:0]
  output logic [schm_pkg::MAKESPAN_W-1:0]  m_axis_tdata_o,
  // task_dropped [0]
  output logic                             m_axis_tuser_o
);

  schm_pkg::cmd_t    cmd;
  schm_pkg::status_t status;

  schm_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  schm_dp #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ===== tb/sv/schm_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Schrage makespan block: watches both stream channels,
// predicts the makespan of every task set and compares each result.
// Depends on schm_pkg only.
module schm_checker #(
  parameter int unsigned MAX_TASKS = schm_pkg::MAX_TASKS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  input  logic                               s_axis_tready_i,
  // release_time [15:0], processing_time [31:16], delivery_time [47:32]
  input  logic [schm_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  input  logic                               s_axis_tlast_i,
  input  logic                               m_axis_tvalid_i,
  input  logic                               m_axis_tready_i,
  // makespan [23:0]
  input  logic [schm_pkg::MAKESPAN_W-1:0]    m_axis_tdata_i,
  // task_dropped [0]
  input  logic                               m_axis_tuser_i,
  output int unsigned                        fail_cnt_o,
  output int unsigned                        pending_o,
  output int unsigned                        checked_o
);

  localparam int unsigned FW = schm_pkg::FIELD_W;
  localparam int unsigned MW = schm_pkg::MAKESPAN_W;

  typedef struct {
    logic [FW-1:0] rel;
    logic [FW-1:0] dur;
    logic [FW-1:0] tail;
  } job_t;

  typedef struct {
    logic [MW-1:0] cmax;
    logic          dropped;
  } outcome_t;

  job_t        set_jobs[$];
  bit          set_overflow = 1'b0;
  outcome_t    cmax_q[$];
  int unsigned fails = 0;
  int unsigned checked = 0;
  int unsigned waiting = 0;

  assign fail_cnt_o = fails;
  assign pending_o  = waiting;
  assign checked_o  = checked;

  // Run the non-preemptive Schrage rule over the collected set.
  function automatic logic [MW-1:0] schrage_cmax();
    logic [63:0] now;
    logic [63:0] cmax;
    logic [63:0] min_rel;
    bit          taken [MAX_TASKS];
    int          remaining;
    int          pick;
    bit          found;
    for (int i = 0; i < MAX_TASKS; i++) taken[i] = 1'b0;
    now       = '0;
    cmax      = '0;
    remaining = set_jobs.size();
    while (remaining > 0) begin
      found   = 1'b0;
      pick    = 0;
      min_rel = '1;
      for (int i = 0; i < set_jobs.size(); i++) begin
        if (!taken[i]) begin
          if (64'(set_jobs[i].rel) < min_rel) min_rel = 64'(set_jobs[i].rel);
          // ready tasks only; largest tail, then smaller release, then order
          if (64'(set_jobs[i].rel) <= now) begin
            if (!found || set_jobs[i].tail > set_jobs[pick].tail ||
                (set_jobs[i].tail == set_jobs[pick].tail &&
                 set_jobs[i].rel < set_jobs[pick].rel)) begin
              pick  = i;
              found = 1'b1;
            end
          end
        end
      end
      if (!found) begin
        // machine idles until the next release
        now = min_rel;
      end else begin
        taken[pick] = 1'b1;
        remaining   = remaining - 1;
        now         = now + 64'(set_jobs[pick].dur);
        if (now + 64'(set_jobs[pick].tail) > cmax) begin
          cmax = now + 64'(set_jobs[pick].tail);
        end
      end
    end
    if (cmax > 64'(schm_pkg::MAKESPAN_MAX)) return schm_pkg::MAKESPAN_MAX;
    return cmax[MW-1:0];
  endfunction

  // Collect requests, predict on the last task, compare each result.
  always @(posedge clk_i) begin : watch
    job_t     job;
    outcome_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        job.rel  = s_axis_tdata_i[FW-1:0];
        job.dur  = s_axis_tdata_i[2*FW-1:FW];
        job.tail = s_axis_tdata_i[3*FW-1:2*FW];
        if (set_jobs.size() < MAX_TASKS) set_jobs = {set_jobs, job};
        else set_overflow = 1'b1;
        if (s_axis_tlast_i) begin
          want.cmax    = schrage_cmax();
          want.dropped = set_overflow;
          cmax_q = {cmax_q, want};
          set_jobs.delete();
          set_overflow = 1'b0;
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (cmax_q.size() == 0) begin
          $error("result with nothing expected: makespan %0d task_dropped %0b",
                 m_axis_tdata_i, m_axis_tuser_i);
          fails = fails + 1;
        end else begin
          want = cmax_q.pop_front();
          checked = checked + 1;
          if (m_axis_tdata_i !== want.cmax) begin
            $error("makespan: expected %0d, actual %0d", want.cmax, m_axis_tdata_i);
            fails = fails + 1;
          end
          if (m_axis_tuser_i !== want.dropped) begin
            $error("task_dropped: expected %0b, actual %0b", want.dropped,
                   m_axis_tuser_i);
            fails = fails + 1;
          end
        end
      end
      waiting = cmax_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the Schrage makespan testbench: clock, reset, task-set stimulus
// and result backpressure. Depends on schm_pkg, schrage_makespan, schm_checker.
module tb_top;

  localparam int unsigned LIMIT        = 1000000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE       = 200;
  localparam int unsigned RANDOM_TASKS = 1000;
  localparam int unsigned FW           = schm_pkg::FIELD_W;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            s_valid;
  logic                            s_ready;
  logic [schm_pkg::IN_DATA_W-1:0]  s_data;
  logic                            s_last;
  logic                            m_valid;
  logic                            m_ready;
  logic [schm_pkg::MAKESPAN_W-1:0] m_data;
  logic                            m_user;

  int unsigned fails;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycles = 0;
  int unsigned sent_jobs = 0;
  int unsigned sent_sets = 0;
  int unsigned full_sets = 0;
  bit          no_idle = 1'b0;
  bit          hold_rx = 1'b0;

  always #5 clk = ~clk;

  schrage_makespan u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  schm_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .fail_cnt_o      (fails),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  // Stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top failed");
      $finish;
    end
  end

  // Offer one task request; valid stays high when no gap follows.
  task automatic send_job(input logic [FW-1:0] rel, input logic [FW-1:0] dur,
                          input logic [FW-1:0] tail, input bit last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {tail, dur, rel};
    s_last  <= last;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sent_jobs = sent_jobs + 1;
    if (last) sent_sets = sent_sets + 1;
  endtask

  // Hold off new requests until every result has come back.
  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Send one set; the style shapes release spread and tail ties.
  task automatic send_random_set(input int unsigned n);
    int unsigned   style;
    logic [FW-1:0] rel;
    logic [FW-1:0] dur;
    logic [FW-1:0] tail;
    style = $urandom_range(0, 3);
    if (n > schm_pkg::MAX_TASKS_DEF) full_sets = full_sets + 1;
    for (int i = 0; i < n; i++) begin
      case (style)
        0: begin
          rel  = FW'($urandom_range(0, 65535));
          dur  = FW'($urandom_range(0, 65535));
          tail = FW'($urandom_range(0, 65535));
        end
        1: begin
          rel  = FW'($urandom_range(0, 255));
          dur  = FW'($urandom_range(0, 63));
          tail = FW'($urandom_range(0, 7));
        end
        2: begin
          rel  = FW'($urandom_range(0, 65535));
          dur  = FW'($urandom_range(0, 255));
          tail = FW'($urandom_range(0, 65535));
        end
        default: begin
          rel  = FW'($urandom_range(0, 1023));
          dur  = FW'($urandom_range(0, 31));
          tail = FW'($urandom_range(0, 3));
        end
      endcase
      send_job(rel, dur, tail, i == n - 1);
    end
  endtask

  function automatic int unsigned pick_set_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 8);
    if (roll < 92) return $urandom_range(9, 24);
    if (roll < 98) return $urandom_range(25, 64);
    return $urandom_range(65, 68);
  endfunction

  // Result side: random stalls, a long hold-off on request.
  initial begin : rx_side
    int unsigned stall;
    m_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_rx) begin
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_ready <= 1'b0;
        // sometimes let the result sit before stalling on it
        if ($urandom_range(0, 1)) begin
          @(posedge clk);
          while (!m_valid) @(posedge clk);
        end
        repeat (stall) @(posedge clk);
      end
      m_ready <= 1'b1;
      @(posedge clk);
      while (!m_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned random_start;
    int unsigned set_idx;
    s_valid <= 1'b0;
    s_data  <= '0;
    s_last  <= 1'b0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero task, all-max task
    send_job(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    // equal tails, smaller release wins
    send_job(16'd0, 16'd10, 16'd1, 1'b0);
    send_job(16'd5, 16'd2, 16'd7, 1'b0);
    send_job(16'd3, 16'd4, 16'd7, 1'b1);
    // full tie broken by input order, after an idle jump
    send_job(16'd2, 16'd3, 16'd9, 1'b0);
    send_job(16'd2, 16'd5, 16'd9, 1'b0);
    send_job(16'd2, 16'd1, 16'd9, 1'b1);
    // machine idles more than once
    send_job(16'd100, 16'd5, 16'd0, 1'b0);
    send_job(16'd50, 16'd7, 16'd3, 1'b0);
    send_job(16'd400, 16'd1, 16'hFFFF, 1'b1);
    // extremes mixed to build large sums
    send_job(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    send_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_job(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    send_job(16'hFFFF, 16'h0000, 16'h0000, 1'b1);
    // alternating bit patterns
    send_job(16'h0001, 16'h0001, 16'h0001, 1'b0);
    send_job(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
    send_job(16'h5555, 16'hAAAA, 16'h5555, 1'b1);
    drain();

    // Store full, and the dropped task carries the last flag
    random_start = sent_jobs;
    send_random_set(schm_pkg::MAX_TASKS_DEF + 1);
    drain();

    // Random sets
    set_idx = 0;
    while (sent_jobs - random_start < RANDOM_TASKS) begin
      set_idx = set_idx + 1;
      if (set_idx == 10) begin
        // stall the result side while short sets keep coming
        drain();
        hold_rx = 1'b1;
        no_idle = 1'b1;
        repeat (6) send_random_set($urandom_range(1, 3));
        no_idle = 1'b0;
      end else begin
        no_idle = ($urandom_range(0, 7) == 0);
        send_random_set(pick_set_size());
        if (set_idx % 20 == 0) drain();
      end
    end
    no_idle = 1'b0;
    drain();
    repeat (SETTLE) @(posedge clk);

    $display("sent %0d tasks in %0d sets (%0d over store capacity)", sent_jobs,
             sent_sets, full_sets);
    $display("checked %0d makespan results, %0d mismatches", checked, fails);
    if (fails == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
